FILE: rtl/sblru_pkg.sv
`default_nettype none
package sblru_pkg;

  localparam int unsigned DefEntries = 32;
  localparam int unsigned DefKeyBits = 32;

  localparam int unsigned KeyW   = 32;
  localparam int unsigned SizeW  = 32;
  localparam int unsigned BudgW  = 32;
  localparam int unsigned EvictW = 7;
  localparam int unsigned TotW   = 33;

  localparam logic [BudgW-1:0] BudgetRst = 32'd65536;

  typedef logic [KeyW-1:0]   key_t;
  typedef logic [SizeW-1:0]  size_t;
  typedef logic [BudgW-1:0]  budget_t;
  typedef logic [EvictW-1:0] evict_t;

endpackage
`default_nettype wire

FILE: rtl/sblru_if.sv
`default_nettype none
interface sblru_req_if;
  import sblru_pkg::*;
  logic  valid;
  logic  ready;
  key_t  object_key;
  size_t object_size;
  modport source (output valid, output object_key, output object_size, input ready);
  modport sink   (input valid, input object_key, input object_size, output ready);
endinterface

interface sblru_rsp_if;
  import sblru_pkg::*;
  logic       valid;
  logic       ready;
  logic       hit;
  logic       bypassed;
  evict_t     evicted_count;
  logic [31:0] bytes_in_use;
  modport source (output valid, output hit, output bypassed, output evicted_count,
                  output bytes_in_use, input ready);
  modport sink   (input valid, input hit, input bypassed, input evicted_count,
                  input bytes_in_use, output ready);
endinterface

interface sblru_cfg_if;
  import sblru_pkg::*;
  logic    valid;
  logic    ready;
  budget_t byte_budget;
  modport source (output valid, output byte_budget, input ready);
  modport sink   (input valid, input byte_budget, output ready);
endinterface
`default_nettype wire

FILE: rtl/size_budget_lru_cache.sv
// each request takes one lookup sweep and, unless bypassed, one rank update sweep
//   over the entry memory (one entry per cycle, one read port)
// each eviction forced by the byte budget after an insert adds one more sweep
// throughput: one request at a time, a new one taken once the previous result is queued
// reset: valid bits, byte total and budget (65536) are set at once, no clearing sweep
`default_nettype none
module size_budget_lru_cache #(
  parameter int unsigned ENTRIES  = sblru_pkg::DefEntries,
  parameter int unsigned KEY_BITS = sblru_pkg::DefKeyBits
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  sblru_req_if.sink       req_i,
  sblru_cfg_if.sink       cfg_i,
  sblru_rsp_if.source     rsp_o
);
  import sblru_pkg::*;

  localparam int unsigned RW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int unsigned CW = $clog2(ENTRIES + 1);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_SCAN   = 3'd1;
  localparam logic [2:0] S_PASS   = 3'd2;
  localparam logic [2:0] S_EVCHK  = 3'd3;
  localparam logic [2:0] S_EVSCAN = 3'd4;
  localparam logic [2:0] S_FIN    = 3'd5;

  typedef struct packed {
    logic [KEY_BITS-1:0] key;
    size_t               bytes;
    logic [RW-1:0]       rank;
  } ent_t;

  ent_t mem [ENTRIES];
  ent_t rd_q, wd;
  logic we;

  logic [2:0]          st_q;
  logic [CW-1:0]       a_q, cnt_q;
  logic                rv_q;
  logic [RW-1:0]       ri_q;
  logic [ENTRIES-1:0]  vld_q;
  logic [TotW-1:0]     total_q;
  budget_t             budget_q;
  logic                out_valid_q;

  logic [KEY_BITS-1:0] key_q;
  size_t               size_q;
  logic                hit_q, byp_q;
  evict_t              ev_q;
  logic [RW-1:0]       slot_q;

  logic                fnd_q, fnd_d;
  logic [RW-1:0]       fidx_q, fidx_d, frank_q, frank_d;
  logic                free_ok_q, free_ok_d;
  logic [RW-1:0]       free_idx_q, free_idx_d;
  logic                old_ok_q, old_ok_d;
  logic [RW-1:0]       old_idx_q, old_idx_d, old_rank_q, old_rank_d;
  size_t               old_bytes_q, old_bytes_d;

  logic                out_hit_q, out_byp_q;
  evict_t              out_ev_q;
  logic [31:0]         out_bytes_q;

  logic issue, last, req_xfer;

  assign req_xfer = req_i.valid && req_i.ready;
  assign issue    = (st_q == S_SCAN || st_q == S_PASS || st_q == S_EVSCAN)
                    && (a_q < CW'(ENTRIES));
  assign last     = rv_q && (ri_q == RW'(ENTRIES - 1));

  assign req_i.ready         = (st_q == S_IDLE);
  assign cfg_i.ready         = 1'b1;
  assign rsp_o.valid         = out_valid_q;
  assign rsp_o.hit           = out_hit_q;
  assign rsp_o.bypassed      = out_byp_q;
  assign rsp_o.evicted_count = out_ev_q;
  assign rsp_o.bytes_in_use  = out_bytes_q;

  // entry memory, registered read
  always_ff @(posedge clk_i) begin
    rd_q <= mem[a_q[RW-1:0]];
    if (we) begin
      mem[ri_q] <= wd;
    end
  end

  // rank update and insert write-back during the second sweep
  always_comb begin
    we = 1'b0;
    wd = rd_q;
    if (st_q == S_PASS && rv_q) begin
      if (hit_q) begin
        if (ri_q == fidx_q) begin
          we      = 1'b1;
          wd.rank = '0;
        end else if (vld_q[ri_q] && rd_q.rank < frank_q) begin
          we      = 1'b1;
          wd.rank = RW'(rd_q.rank + 1'b1);
        end
      end else begin
        if (ri_q == slot_q) begin
          we       = 1'b1;
          wd.key   = key_q;
          wd.bytes = size_q;
          wd.rank  = '0;
        end else if (vld_q[ri_q]) begin
          we      = 1'b1;
          wd.rank = RW'(rd_q.rank + 1'b1);
        end
      end
    end
  end

  // lookup tracking: first key match, first free slot, least recent entry
  always_comb begin
    fnd_d       = fnd_q;
    fidx_d      = fidx_q;
    frank_d     = frank_q;
    free_ok_d   = free_ok_q;
    free_idx_d  = free_idx_q;
    old_ok_d    = old_ok_q;
    old_idx_d   = old_idx_q;
    old_rank_d  = old_rank_q;
    old_bytes_d = old_bytes_q;
    if (rv_q) begin
      if (vld_q[ri_q]) begin
        if (!fnd_q && rd_q.key == key_q) begin
          fnd_d   = 1'b1;
          fidx_d  = ri_q;
          frank_d = rd_q.rank;
        end
        if (!old_ok_q || rd_q.rank > old_rank_q) begin
          old_ok_d    = 1'b1;
          old_idx_d   = ri_q;
          old_rank_d  = rd_q.rank;
          old_bytes_d = rd_q.bytes;
        end
      end else if (!free_ok_q) begin
        free_ok_d  = 1'b1;
        free_idx_d = ri_q;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q        <= S_IDLE;
      a_q         <= '0;
      rv_q        <= 1'b0;
      ri_q        <= '0;
      vld_q       <= '0;
      cnt_q       <= '0;
      total_q     <= '0;
      budget_q    <= BudgetRst;
      out_valid_q <= 1'b0;
      fnd_q       <= 1'b0;
      free_ok_q   <= 1'b0;
      old_ok_q    <= 1'b0;
    end else begin
      if (cfg_i.valid) begin
        budget_q <= cfg_i.byte_budget;
      end
      if (rsp_o.ready) begin
        out_valid_q <= 1'b0;
      end
      if (issue) begin
        a_q <= a_q + 1'b1;
      end
      rv_q      <= issue;
      ri_q      <= a_q[RW-1:0];
      fnd_q     <= fnd_d;
      free_ok_q <= free_ok_d;
      old_ok_q  <= old_ok_d;

      case (st_q)
        S_IDLE: begin
          if (req_xfer) begin
            fnd_q     <= 1'b0;
            free_ok_q <= 1'b0;
            old_ok_q  <= 1'b0;
            a_q       <= '0;
            st_q      <= S_SCAN;
          end
        end
        S_SCAN: begin
          if (last) begin
            a_q <= '0;
            if (fnd_d) begin
              st_q <= S_PASS;
            end else if (size_q > budget_q) begin
              vld_q   <= '0;
              cnt_q   <= '0;
              total_q <= '0;
              st_q    <= S_FIN;
            end else if (free_ok_d) begin
              st_q <= S_PASS;
            end else begin
              // full table: the least recent entry gives up its slot
              vld_q[old_idx_d] <= 1'b0;
              total_q          <= total_q - TotW'(old_bytes_d);
              cnt_q            <= cnt_q - 1'b1;
              st_q             <= S_PASS;
            end
          end
        end
        S_PASS: begin
          if (last) begin
            if (hit_q) begin
              st_q <= S_FIN;
            end else begin
              vld_q[slot_q] <= 1'b1;
              cnt_q         <= cnt_q + 1'b1;
              total_q       <= total_q + TotW'(size_q);
              st_q          <= S_EVCHK;
            end
          end
        end
        S_EVCHK: begin
          if (total_q > TotW'(budget_q) && cnt_q != '0) begin
            old_ok_q <= 1'b0;
            a_q      <= '0;
            st_q     <= S_EVSCAN;
          end else begin
            st_q <= S_FIN;
          end
        end
        S_EVSCAN: begin
          if (last) begin
            if (old_ok_d) begin
              vld_q[old_idx_d] <= 1'b0;
              total_q          <= total_q - TotW'(old_bytes_d);
              cnt_q            <= cnt_q - 1'b1;
            end
            st_q <= S_EVCHK;
          end
        end
        S_FIN: begin
          if (!out_valid_q || rsp_o.ready) begin
            out_valid_q <= 1'b1;
            st_q        <= S_IDLE;
          end
        end
        default: begin
          st_q <= S_IDLE;
        end
      endcase
    end
  end

  // request payload, lookup results and the result register
  always_ff @(posedge clk_i) begin
    fidx_q      <= fidx_d;
    frank_q     <= frank_d;
    free_idx_q  <= free_idx_d;
    old_idx_q   <= old_idx_d;
    old_rank_q  <= old_rank_d;
    old_bytes_q <= old_bytes_d;
    case (st_q)
      S_IDLE: begin
        if (req_xfer) begin
          key_q  <= KEY_BITS'(req_i.object_key);
          size_q <= req_i.object_size;
          hit_q  <= 1'b0;
          byp_q  <= 1'b0;
          ev_q   <= '0;
        end
      end
      S_SCAN: begin
        if (last) begin
          if (fnd_d) begin
            hit_q <= 1'b1;
          end else if (size_q > budget_q) begin
            byp_q <= 1'b1;
            ev_q  <= EvictW'(cnt_q);
          end else if (free_ok_d) begin
            slot_q <= free_idx_d;
          end else begin
            slot_q <= old_idx_d;
            ev_q   <= EvictW'(1);
          end
        end
      end
      S_EVSCAN: begin
        if (last && old_ok_d) begin
          ev_q <= ev_q + 1'b1;
        end
      end
      S_FIN: begin
        if (!out_valid_q || rsp_o.ready) begin
          out_hit_q   <= hit_q;
          out_byp_q   <= byp_q;
          out_ev_q    <= ev_q;
          out_bytes_q <= total_q[31:0];
        end
      end
      default: begin
      end
    endcase
  end

endmodule
`default_nettype wire

FILE: rtl/sblru_chk.sv
`default_nettype none
module sblru_chk (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic        hit,
  input wire logic        bypassed,
  input wire logic [6:0]  evicted_count,
  input wire logic [31:0] bytes_in_use
);

  a_hit_byp_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid |-> !(hit && bypassed))
    else $error("hit and bypass reported together");

  a_hit_no_evict: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid && hit) |-> (evicted_count == 7'd0))
    else $error("hit removed entries");

  a_byp_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid && bypassed) |-> (bytes_in_use == 32'd0))
    else $error("bypass left bytes in use");

  a_rsp_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid && !out_ready) |=> (out_valid && $stable(bytes_in_use)
                                   && $stable(evicted_count)))
    else $error("stalled result changed");

endmodule

bind size_budget_lru_cache sblru_chk u_sblru_chk (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .out_valid     (rsp_o.valid),
  .out_ready     (rsp_o.ready),
  .hit           (rsp_o.hit),
  .bypassed      (rsp_o.bypassed),
  .evicted_count (rsp_o.evicted_count),
  .bytes_in_use  (rsp_o.bytes_in_use)
);
`default_nettype wire
